[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Under synthesis the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, ck, rs, ante, cons)
`define ASSERT_NEXT(label, ck, rs, ante, cons)

`endif

`endif

[hw/rtl/ncsc_pkg.sv]
// ----------------------------------------------------------------------------
// ncsc_pkg
// Shared types, sizes and helpers of the nearest-center sphere compositor.
// ----------------------------------------------------------------------------
package ncsc_pkg;

  localparam int MAX_SPHERE_ROWS = 512;
  localparam int MAX_SPHERE_COLS = 1024;
  localparam int MAX_IMAGE_ROWS  = 512;
  localparam int MAX_IMAGE_COLS  = 512;

  // sphere entry address is {row, col}
  localparam int SROW_W = $clog2(MAX_SPHERE_ROWS);
  localparam int SCOL_W = $clog2(MAX_SPHERE_COLS);
  localparam int ADDR_W = SROW_W + SCOL_W;

  // field widths
  localparam int ROW_W   = 9;
  localparam int COL_W   = 10;
  localparam int COLOR_W = 24;
  localparam int DIST_W  = 18;
  localparam int MODE_W  = 2;

  // register widths
  localparam int ROWS_W  = 10;
  localparam int COLS_W  = 11;
  localparam int OFFR_W  = 10;
  localparam int OFFC_W  = 11;

  // stream and config port widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // position arithmetic
  localparam int SUM_W  = 13;
  localparam int WRAP_W = 11;
  localparam int CNT_W  = $clog2(WRAP_W + 1);
  localparam int DIFF_W = 10;
  localparam int PROD_W = 2 * DIFF_W;

  localparam logic [DIST_W-1:0] DIST_ONES = '1;
  localparam logic [DIST_W-1:0] DIST_SAT  = DIST_ONES - DIST_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_COMPOSITE = 2'd0,
    MODE_READ      = 2'd1,
    MODE_CLEAR     = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPHERE_ROWS  = 3'd0,
    REG_SPHERE_COLS  = 3'd1,
    REG_IMAGE_ROWS   = 3'd2,
    REG_IMAGE_COLS   = 3'd3,
    REG_OFFSET_PHI   = 3'd4,
    REG_OFFSET_THETA = 3'd5
  } cfg_reg_t;

  // request to the modulo unit: signed value as sign and magnitude
  typedef struct packed {
    logic              neg;
    logic [WRAP_W-1:0] mag;
    logic [WRAP_W-1:0] modulus;
  } wrap_req_t;

  // zero reads as one, anything above the limit saturates
  function automatic logic [CFG_DATA_W-1:0] clamp_size(
    input logic [CFG_DATA_W-1:0] v,
    input logic [CFG_DATA_W-1:0] lim
  );
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hw/rtl/nearest_center_sphere_compositor.sv]
// ----------------------------------------------------------------------------
// nearest_center_sphere_compositor
// Paints warped image pixels into a sphere buffer, keeping at each entry the
// pixel closest to its image center; also reads and clears single entries.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  cfg       in   cfg_wen                        cfg_addr, cfg_wdata
//  s_axis    in   s_axis_tvalid/s_axis_tready    s_axis_tdata, s_axis_tuser
//  m_axis    out  m_axis_tvalid/m_axis_tready    m_axis_tdata
//
// one item at a time; the composite time is set by the two 11-step bit-serial
// modulo units. after reset the distance memory is swept to all ones, during
// which no item is accepted (config writes are taken).
// the next item is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_center_sphere_compositor
  import ncsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_index[8:0], col_index[18:9], mask_set[19], pixel_color[43:20]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_color[23:0], covered[24], written[25]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_ACCESS,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_COMP,
    OP_READ,
    OP_CLEAR
  } op_t;

  // configuration, sizes kept already clamped
  logic [ROWS_W-1:0]        srows;
  logic [COLS_W-1:0]        scols;
  logic [ROWS_W-1:0]        irows;
  logic [ROWS_W-1:0]        icols;
  logic signed [OFFR_W-1:0] offset_phi;
  logic signed [OFFC_W-1:0] offset_theta;

  always_ff @(posedge clk) begin
    if (rst) begin
      srows        <= ROWS_W'(MAX_SPHERE_ROWS);
      scols        <= COLS_W'(MAX_SPHERE_COLS);
      irows        <= ROWS_W'(MAX_IMAGE_ROWS);
      icols        <= ROWS_W'(MAX_IMAGE_COLS);
      offset_phi   <= '0;
      offset_theta <= '0;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SPHERE_ROWS: srows <= ROWS_W'(clamp_size(
          CFG_DATA_W'(cfg_wdata[ROWS_W-1:0]), CFG_DATA_W'(MAX_SPHERE_ROWS)));
        REG_SPHERE_COLS: scols <= COLS_W'(clamp_size(
          CFG_DATA_W'(cfg_wdata[COLS_W-1:0]), CFG_DATA_W'(MAX_SPHERE_COLS)));
        REG_IMAGE_ROWS: irows <= ROWS_W'(clamp_size(
          CFG_DATA_W'(cfg_wdata[ROWS_W-1:0]), CFG_DATA_W'(MAX_IMAGE_ROWS)));
        REG_IMAGE_COLS: icols <= ROWS_W'(clamp_size(
          CFG_DATA_W'(cfg_wdata[ROWS_W-1:0]), CFG_DATA_W'(MAX_IMAGE_COLS)));
        REG_OFFSET_PHI:   offset_phi   <= cfg_wdata[OFFR_W-1:0];
        REG_OFFSET_THETA: offset_theta <= cfg_wdata[OFFC_W-1:0];
        default: ;
      endcase
    end
  end

  // input word
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic               in_mask;
  logic [COLOR_W-1:0] in_color;
  mode_t              in_mode;
  logic               in_fire;
  logic               img_hit;
  logic               sph_hit;
  op_t                in_op;

  assign in_row   = s_axis_tdata[ROW_W-1:0];
  assign in_col   = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_mask  = s_axis_tdata[ROW_W+COL_W];
  assign in_color = s_axis_tdata[ROW_W+COL_W+COLOR_W:ROW_W+COL_W+1];
  assign in_mode  = mode_t'(s_axis_tuser);

  state_t state;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign img_hit = (ROWS_W'(in_row) < irows) && (in_col < icols);
  assign sph_hit = (ROWS_W'(in_row) < srows) && (COLS_W'(in_col) < scols);

  always_comb begin
    in_op = OP_NONE;
    case (in_mode)
      MODE_COMPOSITE: if (img_hit) in_op = OP_COMP;
      MODE_READ:      if (sph_hit) in_op = OP_READ;
      MODE_CLEAR:     if (sph_hit) in_op = OP_CLEAR;
      default:        in_op = OP_NONE;
    endcase
  end

  // shifted and centered position before wrapping
  logic signed [SUM_W-1:0] prow_sum;
  logic signed [SUM_W-1:0] pcol_sum;
  logic signed [SUM_W-1:0] prow_abs;
  logic signed [SUM_W-1:0] pcol_abs;
  wrap_req_t               req_r;
  wrap_req_t               req_c;
  logic                    wrap_start;

  always_comb begin
    prow_sum = SUM_W'(offset_phi) + SUM_W'(in_row) - SUM_W'(irows[ROWS_W-1:1])
             + SUM_W'(srows[ROWS_W-1:1]);
    pcol_sum = SUM_W'(offset_theta) + SUM_W'(in_col) - SUM_W'(icols[ROWS_W-1:1])
             + SUM_W'(scols[COLS_W-1:1]);
    prow_abs = prow_sum[SUM_W-1] ? -prow_sum : prow_sum;
    pcol_abs = pcol_sum[SUM_W-1] ? -pcol_sum : pcol_sum;
    req_r.neg     = prow_sum[SUM_W-1];
    req_r.mag     = prow_abs[WRAP_W-1:0];
    req_r.modulus = WRAP_W'(srows);
    req_c.neg     = pcol_sum[SUM_W-1];
    req_c.mag     = pcol_abs[WRAP_W-1:0];
    req_c.modulus = WRAP_W'(scols);
  end

  assign wrap_start = in_fire && (in_op == OP_COMP);

  logic              wrap_busy_r;
  logic              wrap_busy_c;
  logic [WRAP_W-1:0] wrap_res_r;
  logic [WRAP_W-1:0] wrap_res_c;

  ncsc_wrap u_wrap_row (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .req    (req_r),
    .busy   (wrap_busy_r),
    .result (wrap_res_r)
  );

  ncsc_wrap u_wrap_col (
    .clk    (clk),
    .rst    (rst),
    .start  (wrap_start),
    .req    (req_c),
    .busy   (wrap_busy_c),
    .result (wrap_res_c)
  );

  // squared distance, settles while the modulo units run
  logic signed [DIFF_W-1:0] dr_q;
  logic signed [DIFF_W-1:0] dc_q;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_c;
  logic [DIST_W-1:0]        sq_r;
  logic [DIST_W-1:0]        sq_c;
  logic [DIST_W:0]          dsum;
  logic [DIST_W-1:0]        dist_q;

  assign prod_r = PROD_W'(dr_q) * PROD_W'(dr_q);
  assign prod_c = PROD_W'(dc_q) * PROD_W'(dc_q);
  assign dsum   = {1'b0, sq_r} + {1'b0, sq_c};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dr_q <= DIFF_W'(irows[ROWS_W-1:1]) - DIFF_W'(in_row);
      dc_q <= DIFF_W'(icols[ROWS_W-1:1]) - DIFF_W'(in_col);
    end
    sq_r   <= prod_r[DIST_W-1:0];
    sq_c   <= prod_c[DIST_W-1:0];
    dist_q <= (dsum > {1'b0, DIST_SAT}) ? DIST_SAT : dsum[DIST_W-1:0];
  end

  // memories
  logic               div_done;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic [ADDR_W-1:0]  in_addr;
  logic [ADDR_W-1:0]  wrap_addr;
  logic               dist_we;
  logic [ADDR_W-1:0]  dist_waddr;
  logic [DIST_W-1:0]  dist_wdata;
  logic [DIST_W-1:0]  dist_rdata;
  logic               color_we;
  logic [COLOR_W-1:0] color_rdata;
  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  addr_q;
  op_t                op_q;
  logic               mask_q;
  logic [COLOR_W-1:0] color_q;
  logic               win;

  assign in_addr   = {in_row[SROW_W-1:0], in_col[SCOL_W-1:0]};
  assign wrap_addr = {wrap_res_r[SROW_W-1:0], wrap_res_c[SCOL_W-1:0]};
  assign div_done  = (state == ST_DIV) && !wrap_busy_r && !wrap_busy_c;

  // reads are issued only after the previous item's write has landed
  assign mem_rd_en   = div_done || (in_fire && in_op == OP_READ);
  assign mem_rd_addr = (state == ST_DIV) ? wrap_addr : in_addr;

  assign win = mask_q && (dist_q < dist_rdata);

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = addr_q;
    dist_wdata = DIST_ONES;
    if (state == ST_CLEAR) begin
      dist_we    = 1'b1;
      dist_waddr = clr_addr;
    end else if (in_fire && in_op == OP_CLEAR) begin
      dist_we    = 1'b1;
      dist_waddr = in_addr;
    end else if (state == ST_ACCESS && op_q == OP_COMP && win) begin
      dist_we    = 1'b1;
      dist_wdata = dist_q;
    end
  end

  assign color_we = (state == ST_ACCESS) && (op_q == OP_COMP) && win;

  ncsc_ram #(
    .DATA_W (DIST_W),
    .ADDR_W (ADDR_W)
  ) u_dist_ram (
    .clk     (clk),
    .wr_en   (dist_we),
    .wr_addr (dist_waddr),
    .wr_data (dist_wdata),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (dist_rdata)
  );

  ncsc_ram #(
    .DATA_W (COLOR_W),
    .ADDR_W (ADDR_W)
  ) u_color_ram (
    .clk     (clk),
    .wr_en   (color_we),
    .wr_addr (addr_q),
    .wr_data (color_q),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (color_rdata)
  );

  // sequencer and output register
  logic [COLOR_W-1:0]    res_color;
  logic                  res_cov;
  logic                  res_wr;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      op_q      <= OP_NONE;
    end else begin
      // in the finish state the output register is handled below
      if (out_valid && m_axis_tready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            op_q      <= in_op;
            mask_q    <= in_mask;
            color_q   <= in_color;
            addr_q    <= in_addr;
            res_color <= '0;
            res_cov   <= 1'b0;
            res_wr    <= 1'b0;
            case (in_op)
              OP_COMP: state <= ST_DIV;
              OP_READ: state <= ST_ACCESS;
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            addr_q <= wrap_addr;
            state  <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          if (op_q == OP_COMP) begin
            res_wr  <= win;
            res_cov <= win || (dist_rdata != DIST_ONES);
          end else begin
            res_cov   <= (dist_rdata != DIST_ONES);
            res_color <= (dist_rdata != DIST_ONES) ? color_rdata : '0;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_data  <= OUT_DATA_W'({res_wr, res_cov, res_color});
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  logic               out_cov;
  logic               out_wr;
  logic [COLOR_W-1:0] out_color;

  assign out_color = out_data[COLOR_W-1:0];
  assign out_cov   = out_data[COLOR_W];
  assign out_wr    = out_data[COLOR_W+1];

  `ASSERT_IMPLY(a_ready_units_idle, clk, rst, s_axis_tready, !wrap_busy_r && !wrap_busy_c)
  `ASSERT_NEXT(a_one_item_in_flight, clk, rst, in_fire, !s_axis_tready)
  `ASSERT_IMPLY(a_written_is_covered, clk, rst, out_valid && out_wr, out_cov)
  `ASSERT_IMPLY(a_color_needs_cover, clk, rst, out_valid && out_color != '0, out_cov)

endmodule

[hw/rtl/ncsc_ram.sv]
// ----------------------------------------------------------------------------
// ncsc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ncsc_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/ncsc_wrap.sv]
// ----------------------------------------------------------------------------
// ncsc_wrap
// Bit-serial true modulo: one remainder bit per cycle, sign fixed at the end.
// ----------------------------------------------------------------------------
module ncsc_wrap
  import ncsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  wrap_req_t         req,
  output logic              busy,
  output logic [WRAP_W-1:0] result
);

  logic [CNT_W-1:0]  cnt;
  logic [WRAP_W-1:0] rem;
  logic [WRAP_W-1:0] sh;
  logic [WRAP_W-1:0] modulus;
  logic              neg;
  logic [WRAP_W:0]   trial;

  assign trial = {rem, sh[WRAP_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= CNT_W'(WRAP_W);
      rem     <= '0;
      sh      <= req.mag;
      modulus <= req.modulus;
      neg     <= req.neg;
    end else if (busy) begin
      // restoring step, remainder stays below the modulus
      if (trial >= {1'b0, modulus}) begin
        rem <= WRAP_W'(trial - {1'b0, modulus});
      end else begin
        rem <= trial[WRAP_W-1:0];
      end
      sh  <= sh << 1;
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // negative input with a nonzero remainder folds back into range
  assign result = (neg && rem != '0) ? modulus - rem : rem;

endmodule

[tb/sphere_compositor_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphere_compositor_checker
// Watches the config port and both stream channels of the compositor, keeps
// its own copy of the sphere distance and color memories, predicts the result
// word of every accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module sphere_compositor_checker
  import ncsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // row_index[8:0], col_index[18:9], mask_set[19], pixel_color[43:20]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_color[23:0], covered[24], written[25]
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               covered;
    logic               written;
  } sphere_result_t;

  // sparse copies of the sphere memories, a missing distance reads as all ones
  logic [DIST_W-1:0]  dist_mem  [int];
  logic [COLOR_W-1:0] color_mem [int];

  logic [ROWS_W-1:0]        sph_rows_q;
  logic [COLS_W-1:0]        sph_cols_q;
  logic [ROWS_W-1:0]        img_rows_q;
  logic [ROWS_W-1:0]        img_cols_q;
  logic signed [OFFR_W-1:0] off_phi_q;
  logic signed [OFFC_W-1:0] off_theta_q;

  sphere_result_t sphere_results_q[$];
  int             err_count = 0;
  int             queued    = 0;

  assign mismatches = err_count;
  assign pending    = queued;

  function automatic int fit_size(input int v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // true modulo, result always in [0, n)
  function automatic int wrap_pos(input int p, input int n);
    int r;
    r = p % n;
    if (r < 0) r += n;
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] dist_at(input int a);
    return dist_mem.exists(a) ? dist_mem[a] : DIST_ONES;
  endfunction

  function automatic sphere_result_t next_sphere_result(
    input logic [MODE_W-1:0]  mode_code,
    input int                 row,
    input int                 col,
    input logic               mask,
    input logic [COLOR_W-1:0] color
  );
    sphere_result_t res;
    int srows, scols, irows, icols;
    int hc_r, hc_c, pr, pc, a, dr, dc, d;
    res   = '0;
    srows = fit_size(int'(sph_rows_q), MAX_SPHERE_ROWS);
    scols = fit_size(int'(sph_cols_q), MAX_SPHERE_COLS);
    irows = fit_size(int'(img_rows_q), MAX_IMAGE_ROWS);
    icols = fit_size(int'(img_cols_q), MAX_IMAGE_COLS);
    case (mode_code)
      MODE_COMPOSITE: begin
        if (row < irows && col < icols) begin
          hc_r = irows / 2;
          hc_c = icols / 2;
          pr   = wrap_pos(int'(off_phi_q) + row - hc_r + srows / 2, srows);
          pc   = wrap_pos(int'(off_theta_q) + col - hc_c + scols / 2, scols);
          a    = pr * MAX_SPHERE_COLS + pc;
          dr   = hc_r - row;
          dc   = hc_c - col;
          d    = dr * dr + dc * dc;
          if (d > int'(DIST_SAT)) d = int'(DIST_SAT);
          if (mask && d < int'(dist_at(a))) begin
            dist_mem[a]  = DIST_W'(d);
            color_mem[a] = color;
            res.written  = 1'b1;
          end
          res.covered = (dist_at(a) != DIST_ONES);
        end
      end
      MODE_READ, MODE_CLEAR: begin
        if (row < srows && col < scols) begin
          a = row * MAX_SPHERE_COLS + col;
          if (mode_code == MODE_CLEAR) begin
            dist_mem[a] = DIST_ONES;
          end else if (dist_at(a) != DIST_ONES) begin
            res.covered = 1'b1;
            res.color   = color_mem[a];
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    sphere_result_t exp_w;
    if (rst) begin
      dist_mem.delete();
      color_mem.delete();
      sphere_results_q.delete();
      sph_rows_q  = ROWS_W'(MAX_SPHERE_ROWS);
      sph_cols_q  = COLS_W'(MAX_SPHERE_COLS);
      img_rows_q  = ROWS_W'(MAX_IMAGE_ROWS);
      img_cols_q  = ROWS_W'(MAX_IMAGE_COLS);
      off_phi_q   = '0;
      off_theta_q = '0;
    end else begin
      // results leave before new words enter so a result never meets its own word
      if (m_axis_tvalid && m_axis_tready) begin
        if (sphere_results_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          exp_w = sphere_results_q.pop_front();
          if (m_axis_tdata[23:0] !== exp_w.color) begin
            $display("%0t: read_color expected %h actual %h",
                     $time, exp_w.color, m_axis_tdata[23:0]);
            err_count++;
          end
          if (m_axis_tdata[24] !== exp_w.covered) begin
            $display("%0t: covered expected %b actual %b",
                     $time, exp_w.covered, m_axis_tdata[24]);
            err_count++;
          end
          if (m_axis_tdata[25] !== exp_w.written) begin
            $display("%0t: written expected %b actual %b",
                     $time, exp_w.written, m_axis_tdata[25]);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sphere_results_q.insert(sphere_results_q.size(), next_sphere_result(
          s_axis_tuser, int'(s_axis_tdata[8:0]), int'(s_axis_tdata[18:9]),
          s_axis_tdata[19], s_axis_tdata[43:20]));
      end
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_addr))
          REG_SPHERE_ROWS:  sph_rows_q  = cfg_wdata[ROWS_W-1:0];
          REG_SPHERE_COLS:  sph_cols_q  = cfg_wdata[COLS_W-1:0];
          REG_IMAGE_ROWS:   img_rows_q  = cfg_wdata[ROWS_W-1:0];
          REG_IMAGE_COLS:   img_cols_q  = cfg_wdata[ROWS_W-1:0];
          REG_OFFSET_PHI:   off_phi_q   = signed'(cfg_wdata[OFFR_W-1:0]);
          REG_OFFSET_THETA: off_theta_q = signed'(cfg_wdata[OFFC_W-1:0]);
          default: begin
          end
        endcase
      end
    end
    queued = sphere_results_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the sphere compositor with a directed opening and then phases of
// random composite, read and clear words under many register settings, with
// random gaps and stalls on both streams; the checker module judges results.
// ----------------------------------------------------------------------------
module tb;
  import ncsc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int  PHASE_WORDS   = 140;
  localparam int  PHASE_COUNT   = 12;
  localparam int  SETTLE_CYCLES = 24;
  localparam int  LONG_HOLD     = 300;
  localparam longint RUN_LIMIT_NS = 25_000_000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    mismatches;
  int                    pending;

  // effective sizes, only used to aim the random words
  int eff_srows, eff_scols, eff_irows, eff_icols;

  nearest_center_sphere_compositor u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sphere_compositor_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  // mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int fit_size(input int v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // result side: random stalls after each word, two long hold-offs
  initial begin : sink_proc
    int stall_left;
    int got;
    m_axis_tready = 1'b0;
    stall_left = 0;
    got = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got++;
        if (got == 80 || got == 900) begin
          stall_left = LONG_HOLD;
        end else begin
          stall_left = pick_gap((got / 150) % 3 == 2);
        end
      end
      @(negedge clk);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // called at a falling edge; leaves valid high for a back-to-back word
  task automatic send_word(
    input logic [MODE_W-1:0]  mode_code,
    input logic [ROW_W-1:0]   row,
    input logic [COL_W-1:0]   col,
    input logic               mask,
    input logic [COLOR_W-1:0] color,
    input bit                 calm
  );
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, color, mask, col, row};
    s_axis_tuser  <= mode_code;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input bit calm);
    int pick, row, col;
    logic [MODE_W-1:0] mode_code;
    pick = $urandom_range(0, 99);
    if (pick < 55) mode_code = MODE_COMPOSITE;
    else if (pick < 85) mode_code = MODE_READ;
    else if (pick < 95) mode_code = MODE_CLEAR;
    else mode_code = MODE_UNUSED;
    if ($urandom_range(0, 9) == 0) begin
      row = $urandom_range(0, 511);
      col = $urandom_range(0, 1023);
    end else if (mode_code == MODE_COMPOSITE) begin
      row = $urandom_range(0, eff_irows - 1);
      col = $urandom_range(0, eff_icols - 1);
    end else begin
      row = $urandom_range(0, eff_srows - 1);
      col = $urandom_range(0, eff_scols - 1);
    end
    send_word(mode_code, ROW_W'(row), COL_W'(col), $urandom_range(0, 99) < 85,
              COLOR_W'($urandom), calm);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic configure(
    input int srows, input int scols, input int irows, input int icols,
    input int ophi, input int otheta
  );
    write_reg(REG_SPHERE_ROWS, CFG_DATA_W'(srows));
    write_reg(REG_SPHERE_COLS, CFG_DATA_W'(scols));
    write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(irows));
    write_reg(REG_IMAGE_COLS, CFG_DATA_W'(icols));
    write_reg(REG_OFFSET_PHI, {1'b0, OFFR_W'(ophi)});
    write_reg(REG_OFFSET_THETA, OFFC_W'(otheta));
    cfg_wen <= 1'b0;
    eff_srows = fit_size(srows, MAX_SPHERE_ROWS);
    eff_scols = fit_size(scols, MAX_SPHERE_COLS);
    eff_irows = fit_size(irows, MAX_IMAGE_ROWS);
    eff_icols = fit_size(icols, MAX_IMAGE_COLS);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stim_proc
    int p;
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_addr      = REG_SPHERE_ROWS;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_COMPOSITE;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // register writes are taken while the memory sweep runs
    configure(512, 1024, 512, 512, 0, 0);

    // image center (256,256) lands on sphere entry (256,512)
    send_word(MODE_COMPOSITE, 9'd256, 10'd256, 1'b1, 24'hFFFFFF, 1'b0);
    // equal distance does not replace
    send_word(MODE_COMPOSITE, 9'd256, 10'd256, 1'b1, 24'h000000, 1'b0);
    send_word(MODE_READ, 9'd256, 10'd512, 1'b0, 24'h000000, 1'b0);
    // masked-off pixel, then the same corner pixel with its mask set
    send_word(MODE_COMPOSITE, 9'd0, 10'd0, 1'b0, 24'h5A5A5A, 1'b0);
    send_word(MODE_READ, 9'd0, 10'd256, 1'b1, 24'hFFFFFF, 1'b0);
    send_word(MODE_COMPOSITE, 9'd0, 10'd0, 1'b1, 24'h555555, 1'b0);
    send_word(MODE_COMPOSITE, 9'd511, 10'd511, 1'b1, 24'hAAAAAA, 1'b0);
    // column beyond the image
    send_word(MODE_COMPOSITE, 9'd511, 10'd1023, 1'b1, 24'hFFFFFF, 1'b0);
    send_word(MODE_READ, 9'd511, 10'd1023, 1'b0, 24'h000000, 1'b0);
    // clear hides the color, the next composite takes the entry again
    send_word(MODE_CLEAR, 9'd256, 10'd512, 1'b0, 24'h000000, 1'b0);
    send_word(MODE_READ, 9'd256, 10'd512, 1'b0, 24'h000000, 1'b0);
    send_word(MODE_COMPOSITE, 9'd256, 10'd256, 1'b1, 24'h123456, 1'b0);
    send_word(MODE_READ, 9'd256, 10'd512, 1'b0, 24'h000000, 1'b0);
    send_word(MODE_UNUSED, 9'd511, 10'd1023, 1'b1, 24'hFFFFFF, 1'b0);
    send_word(MODE_READ, 9'd0, 10'd256, 1'b0, 24'h000000, 1'b0);
    send_word(MODE_READ, 9'd511, 10'd767, 1'b0, 24'h000000, 1'b0);
    send_word(MODE_CLEAR, 9'd511, 10'd1023, 1'b1, 24'hFFFFFF, 1'b0);
    send_word(MODE_COMPOSITE, 9'd255, 10'd257, 1'b1, 24'h00FF00, 1'b0);
    send_word(MODE_COMPOSITE, 9'd256, 10'd256, 1'b1, 24'h0F0F0F, 1'b0);
    send_word(MODE_READ, 9'd255, 10'd513, 1'b0, 24'h000000, 1'b0);
    drain();

    for (p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: configure(0, 0, 0, 0, -512, -1024);
        1: configure(1023, 2047, 1023, 1023, 511, 1023);
        2: configure(512, 1024, 512, 512, $urandom_range(0, 1023) - 512,
                     $urandom_range(0, 2047) - 1024);
        default: configure($urandom_range(1, 10), $urandom_range(1, 20),
                           $urandom_range(1, 12), $urandom_range(1, 12),
                           $urandom_range(0, 1023) - 512,
                           $urandom_range(0, 2047) - 1024);
      endcase
      repeat (PHASE_WORDS) send_random(p % 4 == 3);
      drain();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
